>>> rtl/tirc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tirc_pkg
// Shared types and constants of the tile index core.
// ----------------------------------------------------------------------------
package tirc_pkg;
	localparam int INDEX_W    = 64;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;
	localparam int LANE_COUNT = 2;

	localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORDER     = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LO_FIRST  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HI_FIRST  = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_FIRST = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LO_SECOND = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HI_SECOND = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_SECOND = 4'd7;

	typedef struct packed {
		logic two_dim;
		logic last_fastest;
	} mode_t;
endpackage

>>> rtl/tile_index_row_column_major_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_index_row_column_major_core
// Linear index of the regular tile holding a coordinate vector.
// ----------------------------------------------------------------------------
// Usage:
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; ready
//   is always high. Each write, and reset, starts a tile count pass, during
//   which busy is high and start is refused.
//   Input: a word is taken at a clock edge with start high and busy low.
//   Throughput is one word per cycle while busy is low.
//   Output: done rises with the word, after a register chain: an input
//   register, one pipelined divider stage per quotient bit in each lane,
//   then multiply and add stages.
//   The receiver cannot stall; results leave in input order.
//   Reset clears the pipeline and loads the default configuration.
// ----------------------------------------------------------------------------
module tile_index_row_column_major_core import tirc_pkg::*; #(
	parameter int MAX_DIMS    = 2,
	parameter int COORD_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [COORD_WIDTH-1:0] coord_first,
	input  logic [COORD_WIDTH-1:0] coord_second,
	output logic                   done,
	output logic [INDEX_W-1:0]     tile_index,
	output logic                   status,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);
	localparam int CW = COORD_WIDTH;

	logic [1:0]    dim_count_q;
	logic          order_q;
	logic [CW-1:0] lo_q  [LANE_COUNT];
	logic [CW-1:0] hi_q  [LANE_COUNT];
	logic [CW-1:0] ext_q [LANE_COUNT];
	logic [CW-1:0] ext_fix [LANE_COUNT];
	logic [CW-1:0] coord [LANE_COUNT];
	logic          lane_vld [LANE_COUNT];
	logic          lane_bad [LANE_COUNT];
	logic [CW-1:0] lane_t [LANE_COUNT];
	logic [CW:0]   lane_p [LANE_COUNT];
	logic          cnt_busy [LANE_COUNT];
	logic          cfg_wr;
	logic          accept;
	mode_t         mode;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign busy      = cnt_busy[0] || cnt_busy[1];
	assign accept    = start && !busy;
	assign coord[0]  = coord_first;
	assign coord[1]  = coord_second;

	always_comb begin
		mode.two_dim      = (MAX_DIMS > 1) && dim_count_q[1];
		mode.last_fastest = order_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_count_q <= 2'd2;
			order_q     <= 1'b0;
			lo_q[0]     <= '0;
			hi_q[0]     <= '1;
			ext_q[0]    <= CW'(1);
			lo_q[1]     <= '0;
			hi_q[1]     <= '1;
			ext_q[1]    <= CW'(1);
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_DIM_COUNT:  dim_count_q <= cfg_data[1:0];
				REG_ORDER:      order_q     <= cfg_data[0];
				REG_LO_FIRST:   lo_q[0]     <= cfg_data[CW-1:0];
				REG_HI_FIRST:   hi_q[0]     <= cfg_data[CW-1:0];
				REG_EXT_FIRST:  ext_q[0]    <= cfg_data[CW-1:0];
				REG_LO_SECOND:  lo_q[1]     <= cfg_data[CW-1:0];
				REG_HI_SECOND:  hi_q[1]     <= cfg_data[CW-1:0];
				REG_EXT_SECOND: ext_q[1]    <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	for (genvar i = 0; i < LANE_COUNT; i++) begin : g_lane
		assign ext_fix[i] = (ext_q[i] == '0) ? CW'(1) : ext_q[i];
		if (i < MAX_DIMS) begin : g_on
			tirc_lane #(.CW(CW)) u_lane (
				.clk      (clk),
				.arst_n   (arst_n),
				.load     (accept),
				.check_en ((i == 0) || mode.two_dim),
				.coord    (coord[i]),
				.lo       (lo_q[i]),
				.hi       (hi_q[i]),
				.extent   (ext_fix[i]),
				.valid    (lane_vld[i]),
				.bad      (lane_bad[i]),
				.quotient (lane_t[i])
			);
			tirc_count #(.CW(CW)) u_count (
				.clk     (clk),
				.arst_n  (arst_n),
				.restart (cfg_wr),
				.lo      (lo_q[i]),
				.hi      (hi_q[i]),
				.extent  (ext_fix[i]),
				.busy    (cnt_busy[i]),
				.count   (lane_p[i])
			);
		end else begin : g_off
			assign lane_vld[i] = 1'b0;
			assign lane_bad[i] = 1'b0;
			assign lane_t[i]   = '0;
			assign lane_p[i]   = '0;
			assign cnt_busy[i] = 1'b0;
		end
	end

	tirc_merge #(.CW(CW)) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (lane_vld[0]),
		.bad        (lane_bad[0] || lane_bad[1]),
		.mode       (mode),
		.t0         (lane_t[0]),
		.t1         (mode.two_dim ? lane_t[1] : '0),
		.p0         (lane_p[0]),
		.p1         (lane_p[1]),
		.done       (done),
		.tile_index (tile_index),
		.status     (status)
	);
endmodule

>>> rtl/tirc_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tirc_lane
// One dimension: pipelined restoring divide of the coordinate by the extent,
// one quotient bit per stage, with the domain check carried alongside.
// ----------------------------------------------------------------------------
module tirc_lane import tirc_pkg::*; #(
	parameter int CW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  logic          check_en,
	input  logic [CW-1:0] coord,
	input  logic [CW-1:0] lo,
	input  logic [CW-1:0] hi,
	input  logic [CW-1:0] extent,
	output logic          valid,
	output logic          bad,
	output logic [CW-1:0] quotient
);
	logic [2*CW-1:0] rq_s  [0:CW];
	logic            vld_s [0:CW];
	logic            bad_s [0:CW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rq_s[0]  <= {{CW{1'b0}}, coord};
			bad_s[0] <= check_en && ((coord < lo) || (coord > hi));
		end
	end

	for (genvar k = 0; k < CW; k++) begin : g_step
		logic [CW:0]   trial;
		logic          fits;
		logic [CW-1:0] rem_next;

		always_comb begin
			trial    = {rq_s[k][2*CW-1:CW-1]};
			fits     = (trial >= {1'b0, extent});
			rem_next = fits ? CW'(trial - {1'b0, extent}) : trial[CW-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rq_s[k+1]  <= {rem_next, rq_s[k][CW-2:0], fits};
			bad_s[k+1] <= bad_s[k];
		end
	end

	assign valid    = vld_s[CW];
	assign bad      = bad_s[CW];
	assign quotient = rq_s[CW][CW-1:0];
endmodule

>>> rtl/tirc_count.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tirc_count
// Tile count of one dimension: ceil((hi - lo + 1) / extent), one quotient
// bit per cycle. Reloads after reset and on every restart.
// ----------------------------------------------------------------------------
module tirc_count import tirc_pkg::*; #(
	parameter int CW = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        restart,
	input  logic [CW-1:0] lo,
	input  logic [CW-1:0] hi,
	input  logic [CW-1:0] extent,
	output logic        busy,
	output logic [CW:0] count
);
	localparam int CNT_W = $clog2(CW + 2);

	logic             load_q;
	logic             run_q;
	logic [CNT_W-1:0] step_q;
	logic             empty_q;
	logic [CW-1:0]    rem_q;
	logic [CW:0]      quo_q;
	logic [CW:0]      count_q;
	logic [CW:0]      trial;
	logic             fits;

	always_comb begin
		trial = {rem_q, quo_q[CW]};
		fits  = (trial >= {1'b0, extent});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= 1'b1;
			run_q  <= 1'b0;
			step_q <= '0;
		end else if (restart) begin
			load_q <= 1'b1;
			run_q  <= 1'b0;
		end else if (load_q) begin
			load_q <= 1'b0;
			run_q  <= 1'b1;
			step_q <= CNT_W'(CW + 1);
		end else if (run_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == CNT_W'(1)) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_q) begin
			empty_q <= (hi < lo);
			rem_q   <= '0;
			quo_q   <= {1'b0, hi} - {1'b0, lo} + 1'b1;
		end else if (run_q) begin
			rem_q <= fits ? CW'(trial - {1'b0, extent}) : trial[CW-1:0];
			quo_q <= {quo_q[CW-1:0], fits};
			if (step_q == CNT_W'(1)) begin
				count_q <= '0;
			end
		end
		if (!load_q && !run_q && !restart) begin
			count_q <= empty_q ? '0 : quo_q + (CW+1)'(rem_q != '0);
		end
	end

	assign busy  = load_q || run_q;
	assign count = count_q;
endmodule

>>> rtl/tirc_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tirc_merge
// Combine the lane quotients into the linear index: multiply, then add.
// ----------------------------------------------------------------------------
module tirc_merge import tirc_pkg::*; #(
	parameter int CW = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	input  logic               bad,
	input  mode_t              mode,
	input  logic [CW-1:0]      t0,
	input  logic [CW-1:0]      t1,
	input  logic [CW:0]        p0,
	input  logic [CW:0]        p1,
	output logic               done,
	output logic [INDEX_W-1:0] tile_index,
	output logic               status
);
	logic              vld_s1;
	logic              bad_s1;
	logic              one_s1;
	logic [2*CW-1:0]   prod_s1;
	logic              phi_s1;
	logic [CW-1:0]     a_s1;
	logic [CW-1:0]     add_s1;
	logic [CW-1:0]     t0_s1;
	logic [CW-1:0]     mul_a;
	logic [CW:0]       mul_p;
	logic [INDEX_W-1:0] sum;

	always_comb begin
		mul_a = mode.last_fastest ? t0 : t1;
		mul_p = mode.last_fastest ? p1 : p0;
		sum   = INDEX_W'(prod_s1) + INDEX_W'(add_s1)
		      + (phi_s1 ? (INDEX_W'(a_s1) << CW) : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= valid;
			done   <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		bad_s1  <= bad;
		one_s1  <= !mode.two_dim;
		prod_s1 <= mul_a * mul_p[CW-1:0];
		phi_s1  <= mul_p[CW];
		a_s1    <= mul_a;
		add_s1  <= mode.last_fastest ? t1 : t0;
		t0_s1   <= t0;
		status  <= bad_s1;
		if (bad_s1) begin
			tile_index <= '0;
		end else if (one_s1) begin
			tile_index <= INDEX_W'(t0_s1);
		end else begin
			tile_index <= sum;
		end
	end
endmodule

>>> rtl/tirc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tirc_checker
// Port-level checks of the tile index core: latency, no stray results,
// index cleared on error.
// ----------------------------------------------------------------------------
module tirc_checker import tirc_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic [INDEX_W-1:0] tile_index,
	input logic               status,
	input logic               cfg_valid,
	input logic               cfg_ready
);
	localparam int LAT = COORD_WIDTH + 3;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result missing after accepted word");

	a_no_stray: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !$past(start && !busy, LAT)) |-> 1'b0)
		else $error("result without accepted word");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (tile_index == '0))
		else $error("nonzero index on error");

	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> busy)
		else $error("config write did not hold off input");
endmodule

bind tile_index_row_column_major_core tirc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.tile_index (tile_index),
	.status     (status),
	.cfg_valid  (cfg_valid),
	.cfg_ready  (cfg_ready)
);

>>> bench/tb_tile_index_row_column_major_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tile_index_row_column_major_core
// Self-checking bench for the tile index core: a directed table of corner
// cases, then random configurations and coordinates, each result compared
// against a fixed word from the table or an in-bench tile index predictor.
// ----------------------------------------------------------------------------
module tb_tile_index_row_column_major_core;
	import tirc_pkg::*;

	localparam int CW = 32;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd15;

	typedef struct packed {
		logic [INDEX_W-1:0] index;
		logic               status;
	} tile_word_t;

	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [CW-1:0]      a;
		logic [CW-1:0]      b;
		logic               fixed;
		tile_word_t         word;
	} row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [CW-1:0]         coord_first;
	logic [CW-1:0]         coord_second;
	logic                  done;
	logic [INDEX_W-1:0]    tile_index;
	logic                  status;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic [1:0]    sh_dims;
	logic          sh_order;
	logic [CW-1:0] sh_lo [2];
	logic [CW-1:0] sh_hi [2];
	logic [CW-1:0] sh_ext [2];

	tile_word_t pending_tiles [$];
	row_t       stim_rows [$];
	logic       use_fixed;
	tile_word_t fixed_word;
	int         fails;
	int         cycles;

	tile_index_row_column_major_core #(.MAX_DIMS(2), .COORD_WIDTH(CW)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.coord_first(coord_first), .coord_second(coord_second),
		.done(done), .tile_index(tile_index), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [32:0] tile_count(logic [CW-1:0] lo, logic [CW-1:0] hi,
			logic [CW-1:0] ext);
		logic [63:0] span;
		logic [63:0] e;
		if (hi < lo)
			return 33'd0;
		span = 64'(hi) - 64'(lo) + 64'd1;
		e = (ext == '0) ? 64'd1 : 64'(ext);
		return 33'(span / e + ((span % e) != 0 ? 64'd1 : 64'd0));
	endfunction

	function automatic tile_word_t predict_tile(logic [CW-1:0] c0, logic [CW-1:0] c1);
		tile_word_t w;
		logic [63:0] t [2];
		logic [CW-1:0] c [2];
		logic [63:0] e;
		logic [32:0] p0;
		logic [32:0] p1;
		int d;
		logic bad;
		c[0] = c0;
		c[1] = c1;
		d = (sh_dims == 2'd0) ? 1 : ((sh_dims == 2'd3) ? 2 : int'(sh_dims));
		bad = 1'b0;
		t[0] = '0;
		t[1] = '0;
		for (int i = 0; i < d; i++) begin
			if (c[i] < sh_lo[i] || c[i] > sh_hi[i])
				bad = 1'b1;
			e = (sh_ext[i] == '0) ? 64'd1 : 64'(sh_ext[i]);
			t[i] = 64'(c[i]) / e;
		end
		p0 = tile_count(sh_lo[0], sh_hi[0], sh_ext[0]);
		p1 = tile_count(sh_lo[1], sh_hi[1], sh_ext[1]);
		if (bad)
			w.index = '0;
		else if (d == 1)
			w.index = t[0];
		else if (sh_order)
			w.index = t[0] * 64'(p1) + t[1];
		else
			w.index = t[0] + t[1] * 64'(p0);
		w.status = bad;
		return w;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		tile_word_t w;
		if (arst_n) begin
			if (start && !busy)
				pending_tiles.insert(pending_tiles.size(), use_fixed ? fixed_word
					: predict_tile(coord_first, coord_second));
			if (done) begin
				if (pending_tiles.size() == 0) begin
					$error("unexpected word: tile_index %h status %b", tile_index, status);
					fails++;
				end else begin
					w = pending_tiles.pop_front();
					if (tile_index !== w.index) begin
						$error("tile_index expected %h actual %h", w.index, tile_index);
						fails++;
					end
					if (status !== w.status) begin
						$error("status expected %b actual %b", w.status, status);
						fails++;
					end
				end
			end
		end
	end

	task automatic settle();
		while (pending_tiles.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] data);
		settle();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
		case (idx)
			REG_DIM_COUNT:  sh_dims = data[1:0];
			REG_ORDER:      sh_order = data[0];
			REG_LO_FIRST:   sh_lo[0] = data;
			REG_HI_FIRST:   sh_hi[0] = data;
			REG_EXT_FIRST:  sh_ext[0] = data;
			REG_LO_SECOND:  sh_lo[1] = data;
			REG_HI_SECOND:  sh_hi[1] = data;
			REG_EXT_SECOND: sh_ext[1] = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_index = $urandom;
		cfg_data = $urandom;
	endtask

	task automatic send_word(logic [CW-1:0] c0, logic [CW-1:0] c1, logic fix, tile_word_t w);
		@(negedge clk);
		start = 1'b1;
		coord_first = c0;
		coord_second = c1;
		use_fixed = fix;
		fixed_word = w;
		while (busy)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic hold_off(int pct);
		int n;
		if ($urandom_range(99, 0) < pct) begin
			n = $urandom_range(4, 1);
			repeat (n) begin
				@(negedge clk);
				start = 1'b0;
				coord_first = $urandom;
				coord_second = $urandom;
			end
		end
	endtask

	function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] data);
		row_t r;
		r.kind = ROW_CFG;
		r.reg_idx = idx;
		r.a = data;
		r.b = '0;
		r.fixed = 1'b0;
		r.word = '0;
		stim_rows.insert(stim_rows.size(), r);
	endfunction

	function automatic void add_item(logic [CW-1:0] c0, logic [CW-1:0] c1, logic fix,
			logic [INDEX_W-1:0] idx, logic st);
		row_t r;
		r.kind = ROW_ITEM;
		r.reg_idx = '0;
		r.a = c0;
		r.b = c1;
		r.fixed = fix;
		r.word.index = idx;
		r.word.status = st;
		stim_rows.insert(stim_rows.size(), r);
	endfunction

	function automatic logic [CW-1:0] pick_coord(logic [CW-1:0] lo, logic [CW-1:0] hi);
		logic [CW-1:0] span;
		case ($urandom_range(9, 0))
			0: return $urandom;
			1: return lo - 1;
			2: return hi + 1;
			3: return lo;
			4: return hi;
			default: begin
				if (hi < lo)
					return $urandom;
				span = hi - lo;
				if (span == '1)
					return $urandom;
				return lo + ($urandom % (span + 1));
			end
		endcase
	endfunction

	function automatic logic [CW-1:0] pick_extent();
		case ($urandom_range(3, 0))
			0: return '0;
			1: return $urandom_range(16, 1);
			2: return $urandom;
			default: return $urandom_range(1000, 1);
		endcase
	endfunction

	task automatic random_config();
		logic [CW-1:0] lo;
		logic [CW-1:0] hi;
		write_reg(REG_DIM_COUNT, $urandom);
		write_reg(REG_ORDER, $urandom);
		for (int i = 0; i < 2; i++) begin
			case ($urandom_range(3, 0))
				0: begin lo = '0; hi = '1; end
				1: begin
					lo = $urandom;
					hi = lo + $urandom_range(5000, 0);
					if (hi < lo)
						hi = '1;
				end
				2: begin lo = $urandom; hi = $urandom; end
				default: begin hi = $urandom_range(1000, 0); lo = hi + $urandom_range(50, 1); end
			endcase
			write_reg(i == 0 ? REG_LO_FIRST : REG_LO_SECOND, lo);
			write_reg(i == 0 ? REG_HI_FIRST : REG_HI_SECOND, hi);
			write_reg(i == 0 ? REG_EXT_FIRST : REG_EXT_SECOND, pick_extent());
		end
		if ($urandom_range(3, 0) == 0)
			write_reg(4'($urandom_range(15, 8)), $urandom);
	endtask

	initial begin
		int pct;
		tile_word_t none;
		none = '0;
		fails = 0;
		cycles = 0;
		use_fixed = 1'b0;
		fixed_word = '0;
		arst_n = 1'b0;
		start = 1'b0;
		coord_first = '0;
		coord_second = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sh_dims = 2'd2;
		sh_order = 1'b0;
		sh_lo[0] = '0;
		sh_hi[0] = '1;
		sh_ext[0] = 1;
		sh_lo[1] = '0;
		sh_hi[1] = '1;
		sh_ext[1] = 1;

		add_item(32'd0, 32'd0, 1'b1, 64'd0, 1'b0);
		add_item('1, '1, 1'b1, '1, 1'b0);
		add_item(32'd1, 32'd0, 1'b1, 64'd1, 1'b0);
		add_item(32'd0, 32'd1, 1'b1, 64'h1_0000_0000, 1'b0);
		add_cfg(REG_ORDER, 32'd1);
		add_item(32'd5, 32'd7, 1'b0, '0, 1'b0);
		add_item('1, '1, 1'b0, '0, 1'b0);
		add_cfg(REG_DIM_COUNT, 32'd1);
		add_cfg(REG_LO_FIRST, 32'd10);
		add_cfg(REG_HI_FIRST, 32'd100);
		add_cfg(REG_EXT_FIRST, 32'd7);
		add_item(32'd9, 32'd0, 1'b1, 64'd0, 1'b1);
		add_item(32'd101, 32'd0, 1'b1, 64'd0, 1'b1);
		add_item(32'd10, '1, 1'b0, '0, 1'b0);
		add_item(32'd100, 32'd123, 1'b0, '0, 1'b0);
		add_cfg(REG_DIM_COUNT, 32'd0);
		add_item(32'd50, 32'd5, 1'b0, '0, 1'b0);
		add_cfg(REG_DIM_COUNT, 32'd3);
		add_cfg(REG_LO_SECOND, 32'd20);
		add_cfg(REG_HI_SECOND, 32'd19);
		add_item(32'd50, 32'd20, 1'b1, 64'd0, 1'b1);
		add_cfg(REG_HI_SECOND, '1);
		add_cfg(REG_EXT_SECOND, 32'd0);
		add_cfg(REG_EXT_FIRST, '1);
		add_item(32'd99, '1, 1'b0, '0, 1'b0);
		add_item(32'd10, 32'd20, 1'b0, '0, 1'b0);
		add_cfg(REG_UNUSED, 32'hDEAD_BEEF);
		add_item(32'd55, 32'd30, 1'b0, '0, 1'b0);
		add_cfg(REG_ORDER, 32'd0);
		add_item(32'd100, '1, 1'b0, '0, 1'b0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_CFG) begin
				@(negedge clk);
				start = 1'b0;
				write_reg(stim_rows[i].reg_idx, stim_rows[i].a);
			end else begin
				send_word(stim_rows[i].a, stim_rows[i].b, stim_rows[i].fixed, stim_rows[i].word);
			end
		end

		for (int ph = 0; ph < 17; ph++) begin
			pct = (ph < 6) ? 20 : ((ph < 12) ? 60 : 0);
			@(negedge clk);
			start = 1'b0;
			use_fixed = 1'b0;
			random_config();
			for (int k = 0; k < 100; k++) begin
				hold_off(pct);
				send_word(pick_coord(sh_lo[0], sh_hi[0]), pick_coord(sh_lo[1], sh_hi[1]),
					1'b0, none);
			end
		end

		@(negedge clk);
		start = 1'b0;
		settle();
		if (fails == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
